// ===== rtl/core/spq_pkg.sv =====
// shared types, constants and command codes of the sorted priority queue
package spq_pkg;

  // store depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic               op_ok;
    logic               queue_full;
    logic [3:0]         found_index;
    logic               head_valid;
    logic signed [31:0] head_value;
    logic [4:0]         entry_count;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic apply;
  } dp_cmd_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// controller state machine: sequences capture, compare and update of each item
module spq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spq_pkg::dp_cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // output register can take a new beat
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_APPLY;
      ST_APPLY: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.eval    = 1'b0;
    cmd_o.apply   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval  = 1'b1;
      ST_APPLY: cmd_o.apply = slot_free;
      default: ;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/spq_datapath.sv =====
// datapath: chain of stored cells with per-cell compare, shift update and result register
module spq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::dp_cmd_t   cmd_i,
  input  spq_pkg::in_item_t  in_data_i,
  output spq_pkg::out_item_t out_data_o
);
  import spq_pkg::*;

  logic signed [31:0] entry_q [CAPACITY];
  logic signed [31:0] entry_d [CAPACITY];
  logic signed [31:0] prev_val [CAPACITY];
  logic signed [31:0] next_val [CAPACITY];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         op_q;
  logic signed [31:0] value_q;

  logic [CAPACITY-1:0] ge_q, ge_d, rm_q, rm_d, eq_vec;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    idx_q, idx_d;

  logic      full, ins_ok, rem_ok, find_ok, ge_prev;
  out_item_t out_q, out_d;

  // per-cell compare against the captured value, prefix of matches, first match
  always_comb begin
    logic vld;
    logic acc;
    acc   = 1'b0;
    idx_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      vld       = CNT_W'(i) < cnt_q;
      ge_d[i]   = !vld || (entry_q[i] >= value_q);
      eq_vec[i] = vld && (entry_q[i] == value_q);
      acc       = acc | eq_vec[i];
      rm_d[i]   = acc;
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq_vec[i]) idx_d = IDX_W'(i);
    end
    found_d = |eq_vec;
  end

  // neighbor taps for shifting
  always_comb begin
    prev_val[0]          = value_q;
    next_val[CAPACITY-1] = entry_q[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      prev_val[i]   = entry_q[i-1];
      next_val[i-1] = entry_q[i];
    end
  end

  // operation outcome
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign ins_ok  = (op_q == CMD_INSERT) && !full;
  assign rem_ok  = (op_q == CMD_REMOVE) && found_q;
  assign find_ok = (op_q == CMD_FIND) && found_q;

  // new cell contents and count
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_d[i] = entry_q[i];
      ge_prev    = (i == 0) ? 1'b0 : ge_q[(i == 0) ? 0 : i - 1];
      if (ins_ok) begin
        if (ge_q[i]) entry_d[i] = ge_prev ? prev_val[i] : value_q;
      end else if (rem_ok) begin
        if (rm_q[i]) entry_d[i] = next_val[i];
      end
    end
    if (ins_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rem_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // result beat
  always_comb begin
    out_d.op_ok       = ins_ok || rem_ok || find_ok;
    out_d.queue_full  = (op_q == CMD_INSERT) && full;
    out_d.found_index = (rem_ok || find_ok) ? 4'(idx_q) : 4'd0;
    out_d.head_valid  = (cnt_d != '0);
    out_d.head_value  = (cnt_d != '0) ? entry_d[0] : 32'sd0;
    out_d.entry_count = 5'(cnt_d);
  end

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.apply) begin
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_data_i.cmd;
      value_q <= in_data_i.value;
    end
    if (cmd_i.eval) begin
      ge_q    <= ge_d;
      rm_q    <= rm_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
    if (cmd_i.apply) begin
      out_q <= out_d;
      if (ins_ok || rem_ok) entry_q <= entry_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// top level of the sorted priority queue: controller plus cell datapath
// A store of CAPACITY signed 32-bit values kept in ascending order.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one command beat:
// insert, remove first equal, or find, with one value; code three is a no-op.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns one result
// beat per input beat: ok flag, full flag, found position, head and count.
// Sequence: a beat is accepted in the idle state, the cell compares run in the
// next cycle, and the shift update plus result load follow in the apply state
// once the output register is free. Each item passes through the capture,
// compare and update steps of the controller; the time does not depend on
// how many values are stored.
// The result sits in an output register, so the next input beat is accepted
// while an earlier result still waits. If the receiver stalls, the update of
// the following item waits until the output register is free.
// Reset clears the count and the handshake state; the store is then empty and
// no clearing pass is needed. Inserting into a full store leaves it unchanged
// and flags queue_full.
module sorted_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_item_t out_data_o
);
  import spq_pkg::*;

  dp_cmd_t dp_cmd;

  // sequencing
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // storage and compare cells
  spq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the sorted priority queue
module tb_top;
  import spq_pkg::*;

  // reserved command code, handled as a no-op by the block
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 375;
  localparam int DIR_ROWS     = 25;

  // one row of the directed table
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // shadow copy of the store
  logic signed [31:0] shadow_vals [CAPACITY];
  int                 shadow_cnt = 0;

  out_item_t          result_q [$];
  logic signed [31:0] recent_vals [$];
  int                 err_cnt    = 0;
  int                 send_idle  = 0;
  int                 recv_stall = 0;
  bit                 hold_req   = 1'b0;
  int                 hold_left  = 0;

  // directed rows: extremes, absent values, no-op, full store
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{CMD_FIND,   32'h0000_0000}, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b0, 32'h0000_0000, 5'd0}},
    '{'{CMD_REMOVE, 32'h0000_0005}, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b0, 32'h0000_0000, 5'd0}},
    '{'{CMD_INSERT, 32'h7fff_ffff}, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b1, 32'h7fff_ffff, 5'd1}},
    '{'{CMD_INSERT, 32'h8000_0000}, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b1, 32'h8000_0000, 5'd2}},
    '{'{CMD_FIND,   32'h7fff_ffff}, 1'b1, '{1'b1, 1'b0, 4'd1, 1'b1, 32'h8000_0000, 5'd2}},
    '{'{CMD_FIND,   32'h8000_0000}, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b1, 32'h8000_0000, 5'd2}},
    '{'{CMD_REMOVE, 32'h7fff_ffff}, 1'b1, '{1'b1, 1'b0, 4'd1, 1'b1, 32'h8000_0000, 5'd1}},
    '{'{CMD_NOP,    32'h8000_0000}, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b1, 32'h8000_0000, 5'd1}},
    '{'{CMD_FIND,   32'h7fff_ffff}, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b1, 32'h8000_0000, 5'd1}},
    '{'{CMD_INSERT, 32'hffff_ffff}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0001}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_INSERT, 32'hffff_ffff}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h7fff_ffff}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h8000_0000}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0064}, 1'b0, '0},
    '{'{CMD_INSERT, 32'hffff_ff9c}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h5555_5555}, 1'b0, '0},
    '{'{CMD_INSERT, 32'haaaa_aaaa}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0001}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h7fff_ffff}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h1234_5678}, 1'b0, '0},
    '{'{CMD_INSERT, 32'h0000_0000}, 1'b1, '{1'b0, 1'b1, 4'd0, 1'b1, 32'h8000_0000, 5'd16}}
  };

  sorted_priority_queue i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // apply one command to the shadow store and return the result it gives
  function automatic out_item_t apply_queue_op(in_item_t it);
    out_item_t r;
    int        pos;
    int        hit;
    r   = '0;
    hit = shadow_cnt;
    for (int i = shadow_cnt - 1; i >= 0; i--) begin
      if (shadow_vals[i] == it.value) hit = i;
    end
    case (it.cmd)
      CMD_INSERT: begin
        if (shadow_cnt >= CAPACITY) begin
          r.queue_full = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_cnt && $signed(shadow_vals[pos]) < $signed(it.value)) pos++;
          for (int i = shadow_cnt; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[pos] = it.value;
          shadow_cnt++;
          r.op_ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit < shadow_cnt) begin
          for (int i = hit; i + 1 < shadow_cnt; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_cnt--;
          r.op_ok       = 1'b1;
          r.found_index = hit[3:0];
        end
      end
      CMD_FIND: begin
        if (hit < shadow_cnt) begin
          r.op_ok       = 1'b1;
          r.found_index = hit[3:0];
        end
      end
      default: ;
    endcase
    r.head_valid  = (shadow_cnt > 0);
    r.head_value  = (shadow_cnt > 0) ? shadow_vals[0] : 32'sd0;
    r.entry_count = shadow_cnt[4:0];
    return r;
  endfunction

  // random command, values biased toward ones already inserted
  function automatic in_item_t rand_queue_op(int insert_pct);
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 3) it.cmd = CMD_NOP;
    else if (pick < 3 + insert_pct) it.cmd = CMD_INSERT;
    else if (pick[0]) it.cmd = CMD_REMOVE;
    else it.cmd = CMD_FIND;
    pick = $urandom_range(99);
    if (pick < 40 && recent_vals.size() > 0) begin
      it.value = recent_vals[$urandom_range(recent_vals.size() - 1)];
    end else if (pick < 60) begin
      it.value = $signed($urandom_range(8)) - 4;
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0: it.value = 32'h8000_0000;
        1: it.value = 32'h7fff_ffff;
        2: it.value = 32'h0000_0000;
        default: it.value = 32'hffff_ffff;
      endcase
    end else begin
      it.value = $urandom;
    end
    if (it.cmd == CMD_INSERT) begin
      recent_vals.push_back(it.value);
      if (recent_vals.size() > 24) recent_vals.pop_front();
    end
    return it;
  endfunction

  // offer one beat, starting and ending at a falling edge
  task automatic drive_beat(in_item_t it, logic typed, out_item_t typed_want);
    out_item_t want;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    want = apply_queue_op(it);
    if (typed) want = typed_want;
    result_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("op_ok",       want.op_ok,       out_data.op_ok);
        check_field("queue_full",  want.queue_full,  out_data.queue_full);
        check_field("found_index", want.found_index, out_data.found_index);
        check_field("head_valid",  want.head_valid,  out_data.head_valid);
        check_field("head_value",  want.head_value,  out_data.head_value);
        check_field("entry_count", want.entry_count, out_data.entry_count);
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      drive_beat(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].want);
    end

    // random part: no idling, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      send_idle  = (p == 1) ? 47 : (p == 3) ? 13 : 0;
      recv_stall = (p == 2) ? 47 : (p == 3) ? 13 : 0;
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // alternate filling and draining stretches
        drive_beat(rand_queue_op(((k / 60) % 2) ? 25 : 70), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
